// File: hdl/dtps_pkg.sv
// ----------------------------------------------------------------------------
// dtps_pkg
// Shared types, widths and codes of the diamond tile pick store.
// ----------------------------------------------------------------------------
package dtps_pkg;

	// Grid size. Both counts are powers of two from 2 upward, and their
	// product fits the 12-bit tile number.
	localparam int ROWS = 64;
	localparam int COLS = 64;
	localparam int TILE_COUNT = ROWS * COLS;
	localparam int ROW_W = $clog2(ROWS);
	localparam int COL_W = $clog2(COLS);
	localparam int ADDR_W = ROW_W + COL_W;

	localparam int TILE_W = 12;
	localparam int HALF_W = 15;
	localparam int COORD_W = 24;
	localparam int CENTRE_W = 23;
	localparam int INFO_W = 32;
	localparam int COORD_MAX = 8388607;

	localparam int CX_W = HALF_W + COL_W + 1;
	localparam int CZ_W = HALF_W + ROW_W;
	localparam int C_W = (CX_W > CZ_W) ? CX_W : CZ_W;
	localparam int D_W = ((C_W > COORD_W - 1) ? C_W : COORD_W - 1) + 2;
	localparam int P_W = D_W + HALF_W + 1;
	localparam int K_W = 2 * HALF_W;

	localparam logic [HALF_W-1:0] HALF_WIDTH_RESET = HALF_W'(512);
	localparam logic [HALF_W-1:0] HALF_DEPTH_RESET = HALF_W'(256);

	localparam logic [1:0] OP_READ_IDX = 2'd0;
	localparam logic [1:0] OP_WRITE_IDX = 2'd1;
	localparam logic [1:0] OP_READ_POS = 2'd2;
	localparam logic [1:0] OP_WRITE_POS = 2'd3;

	localparam logic REG_HALF_WIDTH = 1'b0;
	localparam logic REG_HALF_DEPTH = 1'b1;

	typedef struct packed {
		logic [1:0] opcode;
		logic [TILE_W-1:0] tile_select;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_z;
		logic [INFO_W-1:0] new_info;
	} req_t;

	typedef struct packed {
		logic hit;
		logic [TILE_W-1:0] tile_number;
		logic [CENTRE_W-1:0] tile_x;
		logic [CENTRE_W-1:0] tile_z;
		logic [INFO_W-1:0] tile_info;
	} res_t;

	typedef struct packed {
		logic go;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} probe_cmd_t;

	typedef struct packed {
		logic valid;
		logic in_tile;
		logic left;
		logic [CENTRE_W-1:0] cx;
		logic [CENTRE_W-1:0] cz;
	} probe_res_t;

endpackage

// File: hdl/dtps_info_mem.sv
// ----------------------------------------------------------------------------
// dtps_info_mem
// Single-port info word memory with one write or read per cycle and a
// registered read.
// ----------------------------------------------------------------------------
module dtps_info_mem import dtps_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [INFO_W-1:0] wdata,
	output logic [INFO_W-1:0] rdata
);

	logic [INFO_W-1:0] mem_q [TILE_COUNT];
	logic [INFO_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/dtps_probe.sv
// ----------------------------------------------------------------------------
// dtps_probe
// Four-stage tile probe: computes a tile centre, tests the query point
// against the closed diamond and reports on which side of the centre it lies.
// ----------------------------------------------------------------------------
module dtps_probe import dtps_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  probe_cmd_t                cmd,
	input  logic [HALF_W-1:0]         half_width,
	input  logic [HALF_W-1:0]         half_depth,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_z,
	output probe_res_t                res
);

	logic v_s1, v_s2, v_s3, v_s4;

	logic [HALF_W+COL_W-1:0] hwcol_s1;
	logic [CZ_W-1:0] cz_s1;
	logic odd_s1;

	logic [CX_W-1:0] cx_w;
	logic [CX_W-1:0] cx_s2;
	logic [CZ_W-1:0] cz_s2;
	logic signed [D_W-1:0] dx_s2;
	logic signed [D_W-1:0] dz_s2;

	logic signed [P_W-1:0] a_s3;
	logic signed [P_W-1:0] b_s3;
	logic [K_W-1:0] k_s3;
	logic left_s3;
	logic [CENTRE_W-1:0] cx_s3;
	logic [CENTRE_W-1:0] cz_s3;

	logic [P_W-1:0] abs_a;
	logic [P_W-1:0] abs_b;
	logic [P_W:0] abs_sum;
	logic inside_s4;
	logic left_s4;
	logic [CENTRE_W-1:0] cx_s4;
	logic [CENTRE_W-1:0] cz_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cmd.go;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign cx_w = CX_W'({hwcol_s1, 1'b0}) + (odd_s1 ? CX_W'(half_width) : '0);

	assign abs_a = a_s3[P_W-1] ? P_W'(-a_s3) : P_W'(a_s3);
	assign abs_b = b_s3[P_W-1] ? P_W'(-b_s3) : P_W'(b_s3);
	assign abs_sum = (P_W+1)'(abs_a) + (P_W+1)'(abs_b);

	always_ff @(posedge clk) begin
		hwcol_s1 <= (HALF_W+COL_W)'(half_width) * (HALF_W+COL_W)'(cmd.col);
		cz_s1 <= CZ_W'(half_depth) * CZ_W'(cmd.row);
		odd_s1 <= cmd.row[0];

		cx_s2 <= cx_w;
		cz_s2 <= cz_s1;
		dx_s2 <= D_W'(point_x) - $signed(D_W'(cx_w));
		dz_s2 <= D_W'(point_z) - $signed(D_W'(cz_s1));

		a_s3 <= P_W'($signed({1'b0, half_depth})) * P_W'(dx_s2);
		b_s3 <= P_W'($signed({1'b0, half_width})) * P_W'(dz_s2);
		k_s3 <= K_W'(half_width) * K_W'(half_depth);
		left_s3 <= dx_s2[D_W-1];
		cx_s3 <= (32'(cx_s2) > 32'(COORD_MAX)) ? CENTRE_W'(COORD_MAX) : CENTRE_W'(cx_s2);
		cz_s3 <= (32'(cz_s2) > 32'(COORD_MAX)) ? CENTRE_W'(COORD_MAX) : CENTRE_W'(cz_s2);

		// A point is inside the closed diamond when |a| + |b| does not exceed k.
		inside_s4 <= abs_sum <= (P_W+1)'(k_s3);
		left_s4 <= left_s3;
		cx_s4 <= cx_s3;
		cz_s4 <= cz_s3;
	end

	assign res.valid = v_s4;
	assign res.in_tile = inside_s4;
	assign res.left = left_s4;
	assign res.cx = cx_s4;
	assign res.cz = cz_s4;

endmodule

// File: hdl/diamond_tile_pick_store.sv
// ----------------------------------------------------------------------------
// diamond_tile_pick_store
// Info word store for a staggered diamond tile grid, addressed by tile index
// or by a point inside a tile.
//
// A request is taken when start is high and busy is low. Exactly one result
// follows: done is high for one cycle and result is valid in that cycle; the
// receiver takes it then and cannot hold it off. busy stays high from the
// request until the cycle before done, so a new request may be presented
// while done is high.
// Index operations probe the selected tile once for its centre and then
// access the info memory; an out-of-range index skips both and returns a
// zero result. Position operations probe one tile at a time through the
// four-stage probe unit, waiting for each answer before the next probe;
// each row takes up to log2(COLS)+1 probes before the search moves on.
// Reset puts half_width to 512 and half_depth to 256 and then clears all
// 4096 words of the info memory one word a cycle, during which busy is high.
// Configuration writes are taken at any time, including during the clear.
// ----------------------------------------------------------------------------
module diamond_tile_pick_store import dtps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  req_t              request,
	output logic              busy,
	output logic              done,
	output res_t              result,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [HALF_W-1:0] cfg_data
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_PROBE = 3'd2;
	localparam logic [2:0] ST_WAIT = 3'd3;
	localparam logic [2:0] ST_ACCESS = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;

	logic [2:0] state_q;
	logic [HALF_W-1:0] hw_q;
	logic [HALF_W-1:0] hd_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [ROW_W-1:0] row_q;
	logic signed [COL_W+1:0] lo_q;
	logic signed [COL_W+1:0] hi_q;
	logic idx_mode_q;
	logic wr_q;
	logic hit_q;
	logic zero_q;
	logic done_q;

	req_t req_q;
	logic [TILE_W-1:0] tile_q;
	logic [CENTRE_W-1:0] cx_q;
	logic [CENTRE_W-1:0] cz_q;
	res_t result_q;

	logic accept;
	logic is_idx;
	logic is_wr;
	logic out_of_range;
	logic search_live;
	logic last_row;
	logic signed [COL_W+1:0] mid_sum;
	logic [COL_W-1:0] mid_col;
	logic signed [COL_W+1:0] mid_ext;

	probe_cmd_t probe_cmd;
	probe_res_t probe_res;

	logic mem_we;
	logic [ADDR_W-1:0] mem_addr;
	logic [INFO_W-1:0] mem_wdata;
	logic [INFO_W-1:0] mem_rdata;

	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign is_idx = (request.opcode == OP_READ_IDX) || (request.opcode == OP_WRITE_IDX);
	assign is_wr = (request.opcode == OP_WRITE_IDX) || (request.opcode == OP_WRITE_POS);
	assign out_of_range = {1'b0, request.tile_select} >= (TILE_W+1)'(TILE_COUNT);

	assign search_live = lo_q <= hi_q;
	assign last_row = row_q == ROW_W'(ROWS - 1);
	assign mid_sum = lo_q + hi_q;
	assign mid_col = mid_sum[COL_W:1];
	assign mid_ext = (COL_W+2)'(mid_col);

	assign probe_cmd.go = (state_q == ST_PROBE) && search_live;
	assign probe_cmd.row = row_q;
	assign probe_cmd.col = mid_col;

	assign mem_we = (state_q == ST_CLEAR) || ((state_q == ST_ACCESS) && wr_q && hit_q);
	assign mem_addr = (state_q == ST_CLEAR) ? clr_addr_q : tile_q[ADDR_W-1:0];
	assign mem_wdata = (state_q == ST_CLEAR) ? '0 : req_q.new_info;

	dtps_info_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	dtps_probe u_probe (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (probe_cmd),
		.half_width (hw_q),
		.half_depth (hd_q),
		.point_x    (req_q.point_x),
		.point_z    (req_q.point_z),
		.res        (probe_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q <= HALF_WIDTH_RESET;
			hd_q <= HALF_DEPTH_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_HALF_WIDTH) begin
				hw_q <= cfg_data;
			end
			if (cfg_index == REG_HALF_DEPTH) begin
				hd_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_addr_q <= '0;
			row_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			idx_mode_q <= 1'b0;
			wr_q <= 1'b0;
			hit_q <= 1'b0;
			zero_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == ADDR_W'(TILE_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						wr_q <= is_wr;
						idx_mode_q <= is_idx;
						if (is_idx) begin
							if (out_of_range) begin
								hit_q <= 1'b0;
								zero_q <= 1'b1;
								state_q <= ST_EMIT;
							end else begin
								hit_q <= 1'b1;
								zero_q <= 1'b0;
								row_q <= request.tile_select[ADDR_W-1:COL_W];
								lo_q <= (COL_W+2)'(request.tile_select[COL_W-1:0]);
								hi_q <= (COL_W+2)'(request.tile_select[COL_W-1:0]);
								state_q <= ST_PROBE;
							end
						end else begin
							hit_q <= 1'b0;
							zero_q <= 1'b0;
							row_q <= '0;
							lo_q <= '0;
							hi_q <= (COL_W+2)'(COLS - 1);
							state_q <= ST_PROBE;
						end
					end
				end
				ST_PROBE: begin
					if (search_live) begin
						state_q <= ST_WAIT;
					end else if (last_row) begin
						hit_q <= 1'b0;
						state_q <= ST_ACCESS;
					end else begin
						row_q <= row_q + 1'b1;
						lo_q <= '0;
						hi_q <= (COL_W+2)'(COLS - 1);
					end
				end
				ST_WAIT: begin
					if (probe_res.valid) begin
						if (idx_mode_q) begin
							state_q <= ST_ACCESS;
						end else if (probe_res.in_tile) begin
							hit_q <= 1'b1;
							state_q <= ST_ACCESS;
						end else begin
							if (probe_res.left) begin
								hi_q <= mid_ext - (COL_W+2)'(1);
							end else begin
								lo_q <= mid_ext + (COL_W+2)'(1);
							end
							state_q <= ST_PROBE;
						end
					end
				end
				ST_ACCESS: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					done_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					req_q <= request;
					tile_q <= out_of_range ? '0 : request.tile_select;
					cx_q <= '0;
					cz_q <= '0;
				end
			end
			ST_PROBE: begin
				if (!search_live && last_row) begin
					tile_q <= '0;
					cx_q <= '0;
					cz_q <= '0;
				end
			end
			ST_WAIT: begin
				if (probe_res.valid && (idx_mode_q || probe_res.in_tile)) begin
					cx_q <= probe_res.cx;
					cz_q <= probe_res.cz;
					if (!idx_mode_q) begin
						tile_q <= TILE_W'({row_q, mid_col});
					end
				end
			end
			ST_EMIT: begin
				result_q.hit <= hit_q;
				result_q.tile_number <= tile_q;
				result_q.tile_x <= cx_q;
				result_q.tile_z <= cz_q;
				if (zero_q) begin
					result_q.tile_info <= '0;
				end else if (wr_q && hit_q) begin
					result_q.tile_info <= req_q.new_info;
				end else begin
					result_q.tile_info <= mem_rdata;
				end
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign result = result_q;

	// Only one probe is ever in flight, and its answer arrives while waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		probe_res.valid |-> state_q == ST_WAIT)
		else $error("probe result outside of the wait state");

	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_EMIT))
		else $error("result strobe without a finished request");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted request did not raise busy");

endmodule
